[hdl/hpos_pkg.sv]
// Shared codes and types for the huge page order selector.
// Command and status codes, controller-to-datapath command and status structs.
// No dependencies.
package hpos_pkg;

  localparam logic [1:0] CMD_RANGE = 2'd0;
  localparam logic [1:0] CMD_ORDER = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] ST_DECISION = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_NO_RANGE = 3'd2;
  localparam logic [2:0] ST_BAD_MASK = 3'd3;
  localparam logic [2:0] ST_WRITTEN  = 3'd4;

  localparam int ADDR_W  = 64;
  localparam int VALUE_W = 64;
  localparam int ALLOW_W = 16;
  localparam int CHOSEN_W = 9;

  typedef struct packed {
    logic       latch;
    logic       write;
    logic       range_start;
    logic       range_scan;
    logic       order_start;
    logic       order_scan;
    logic       load;
    logic [2:0] status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       bad_mask;
    logic       scan_none;
    logic       range_hit;
    logic       range_miss_last;
    logic       order_done;
  } dp_status_t;

endpackage

[hdl/hpos_ctrl.sv]
// Controller state machine of the huge page order selector.
// Sequences decode, range scan, order scan and result hand-off; holds the enable register.
// Depends on hpos_pkg.
module hpos_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  hpos_pkg::dp_status_t dp_st,
  output hpos_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RSCAN  = 3'd2;
  localparam logic [2:0] S_OSCAN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] status;
  logic [2:0] status_next;
  logic       enabled;
  logic       load;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    cmd.load    = load;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dp_st.command != hpos_pkg::CMD_QUERY) begin
          cmd.write   = 1'b1;
          status_next = hpos_pkg::ST_WRITTEN;
          state_next  = S_FINISH;
        end else if (dp_st.bad_mask) begin
          status_next = hpos_pkg::ST_BAD_MASK;
          state_next  = S_FINISH;
        end else if (!enabled) begin
          status_next = hpos_pkg::ST_DISABLED;
          state_next  = S_FINISH;
        end else begin
          cmd.range_start = 1'b1;
          state_next      = S_RSCAN;
        end
      end
      S_RSCAN: begin
        cmd.range_scan = 1'b1;
        if (dp_st.range_hit) begin
          cmd.order_start = 1'b1;
          status_next     = hpos_pkg::ST_DECISION;
          state_next      = dp_st.scan_none ? S_FINISH : S_OSCAN;
        end else if (dp_st.range_miss_last) begin
          status_next = hpos_pkg::ST_NO_RANGE;
          state_next  = S_FINISH;
        end
      end
      S_OSCAN: begin
        cmd.order_scan = 1'b1;
        if (dp_st.order_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= hpos_pkg::ST_WRITTEN;
      enabled   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      status <= status_next;
      if (cfg_wen) begin
        enabled <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/hpos_dp.sv]
// Datapath of the huge page order selector.
// Holds the range and benefit/cost memories, scan counters, best-order tracking
// and the result register. Depends on hpos_pkg.
module hpos_dp #(
  parameter int NUM_RANGES = 10,
  parameter int NUM_ORDERS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  hpos_pkg::ctrl_cmd_t  cmd,
  output hpos_pkg::dp_status_t dp_st,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_range_slot,
  input  logic [2:0]          in_order_slot,
  input  logic [63:0]         in_first_value,
  input  logic [63:0]         in_second_value,
  input  logic [63:0]         in_query_addr,
  input  logic [15:0]         in_allowed_orders,
  output logic [2:0]          res_status,
  output logic [8:0]          res_chosen_orders,
  output logic [3:0]          res_top_order,
  output logic                res_order_valid,
  output logic [3:0]          res_matched_range
);

  localparam int RW   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int RCW  = $clog2(NUM_RANGES + 1);
  localparam int KW   = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int OD   = NUM_RANGES * NUM_ORDERS;
  localparam int OAW  = (OD > 1) ? $clog2(OD) : 1;
  localparam int MW   = NUM_ORDERS + 1;
  localparam int VW   = hpos_pkg::VALUE_W;

  logic [1:0]   cmd_q;
  logic [3:0]   rs_q;
  logic [2:0]   os_q;
  logic [VW-1:0] v1_q;
  logic [VW-1:0] v2_q;
  logic [hpos_pkg::ADDR_W-1:0] addr_q;
  logic [15:0]  allowed_q;

  logic [2*VW-1:0] range_mem [NUM_RANGES];
  logic [NUM_RANGES-1:0] range_vld;
  logic [2*VW-1:0] order_mem [OD];
  logic [OD-1:0] order_vld;

  logic [RCW-1:0] ridx;
  logic [RW-1:0]  ridx_d;
  logic           rvalid_d;
  logic           r_issue;
  logic [2*VW-1:0] range_rd;
  logic           range_rd_vld;

  logic [RW-1:0]  found;
  logic [KW-1:0]  kidx;
  logic [KW-1:0]  kidx_d;
  logic           opend;
  logic           ovalid_d;
  logic           o_issue;
  logic [OAW-1:0] o_raddr;
  logic [OAW-1:0] o_waddr;
  logic [2*VW-1:0] order_rd;
  logic           order_rd_vld;

  logic [VW-1:0]  profit;
  logic [MW-1:0]  benef;
  logic           any;

  logic [3:0]     a_top;
  logic           a_any;
  logic [VW-1:0]  r_low;
  logic [VW-1:0]  r_high;
  logic           r_match;
  logic [VW-1:0]  ob;
  logic [VW-1:0]  oc;
  logic [VW-1:0]  gain;
  logic [MW-1:0]  obit;
  logic [MW-1:0]  allowed_ext;
  logic [MW-1:0]  mask_full;
  logic [4:0]     m_top;

  always_comb begin
    a_top = '0;
    for (int i = 0; i < hpos_pkg::ALLOW_W; i++) begin
      if (allowed_q[i]) begin
        a_top = 4'(i);
      end
    end
  end

  assign a_any = |allowed_q;

  assign r_low   = range_rd_vld ? range_rd[VW-1:0] : '0;
  assign r_high  = range_rd_vld ? range_rd[2*VW-1:VW] : '0;
  assign r_match = (r_low < addr_q) && (r_high > addr_q);

  assign ob   = order_rd_vld ? order_rd[VW-1:0] : '0;
  assign oc   = order_rd_vld ? order_rd[2*VW-1:VW] : '0;
  assign gain = ob - oc;
  assign obit = MW'(1) << (32'(kidx_d) + 1);

  assign r_issue = cmd.range_scan && (ridx < RCW'(NUM_RANGES));
  assign o_issue = cmd.order_scan && opend;
  assign o_raddr = OAW'(32'(found) * NUM_ORDERS + 32'(kidx));
  assign o_waddr = OAW'(32'(rs_q) * NUM_ORDERS + 32'(os_q));

  assign dp_st.command         = cmd_q;
  assign dp_st.bad_mask        = a_any && ({1'b0, a_top} > 5'(NUM_ORDERS));
  assign dp_st.scan_none       = !a_any || (a_top == 4'd0);
  assign dp_st.range_hit       = cmd.range_scan && rvalid_d && r_match;
  assign dp_st.range_miss_last = cmd.range_scan && rvalid_d && !r_match &&
                                 (ridx_d == RW'(NUM_RANGES - 1));
  assign dp_st.order_done      = cmd.order_scan && ovalid_d && (kidx_d == '0);

  assign allowed_ext = MW'({1'b0, allowed_q});
  assign mask_full   = any ? (benef & allowed_ext) : '0;

  always_comb begin
    m_top = '0;
    for (int i = 0; i < MW; i++) begin
      if (mask_full[i]) begin
        m_top = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q     <= in_command;
      rs_q      <= in_range_slot;
      os_q      <= in_order_slot;
      v1_q      <= in_first_value;
      v2_q      <= in_second_value;
      addr_q    <= in_query_addr;
      allowed_q <= in_allowed_orders;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_vld <= '0;
      order_vld <= '0;
    end else if (cmd.write) begin
      if (cmd_q == hpos_pkg::CMD_RANGE && 32'(rs_q) < NUM_RANGES) begin
        range_vld[RW'(rs_q)] <= 1'b1;
      end
      if (cmd_q == hpos_pkg::CMD_ORDER && 32'(rs_q) < NUM_RANGES &&
          32'(os_q) < NUM_ORDERS) begin
        order_vld[o_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd_q == hpos_pkg::CMD_RANGE && 32'(rs_q) < NUM_RANGES) begin
      range_mem[RW'(rs_q)] <= {v2_q, v1_q};
    end
    if (r_issue) begin
      range_rd     <= range_mem[ridx[RW-1:0]];
      range_rd_vld <= range_vld[ridx[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd_q == hpos_pkg::CMD_ORDER && 32'(rs_q) < NUM_RANGES &&
        32'(os_q) < NUM_ORDERS) begin
      order_mem[o_waddr] <= {v2_q, v1_q};
    end
    if (o_issue) begin
      order_rd     <= order_mem[o_raddr];
      order_rd_vld <= order_vld[o_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ridx     <= '0;
      rvalid_d <= 1'b0;
      opend    <= 1'b0;
      ovalid_d <= 1'b0;
    end else begin
      rvalid_d <= r_issue;
      ovalid_d <= o_issue;
      if (cmd.range_start) begin
        ridx <= '0;
      end else if (r_issue) begin
        ridx <= ridx + RCW'(1);
      end
      if (cmd.order_start) begin
        opend <= !dp_st.scan_none;
      end else if (o_issue && kidx == '0) begin
        opend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_issue) begin
      ridx_d <= ridx[RW-1:0];
    end
    if (o_issue) begin
      kidx_d <= kidx;
    end
    if (cmd.order_start) begin
      found  <= ridx_d;
      kidx   <= KW'({1'b0, a_top} - 5'd1);
      profit <= '0;
      benef  <= '0;
      any    <= 1'b0;
    end else begin
      if (o_issue) begin
        kidx <= kidx - KW'(1);
      end
      if (cmd.order_scan && ovalid_d && (ob > oc)) begin
        if (gain > profit) begin
          profit <= gain;
          benef  <= obit;
          any    <= 1'b1;
        end else begin
          benef <= benef | obit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= cmd.status;
      if (cmd.status == hpos_pkg::ST_DECISION) begin
        res_chosen_orders <= hpos_pkg::CHOSEN_W'(mask_full);
        res_top_order     <= m_top[3:0];
        res_order_valid   <= |mask_full;
        res_matched_range <= 4'(found);
      end else begin
        res_chosen_orders <= '0;
        res_top_order     <= '0;
        res_order_valid   <= 1'b0;
        res_matched_range <= '0;
      end
    end
  end

endmodule

[hdl/huge_page_order_selector.sv]
// Top level of the huge page order selector.
// Unpacks the stream channels and joins hpos_ctrl and hpos_dp.
// Depends on hpos_pkg, hpos_ctrl, hpos_dp.
//
// Usage:
//   The slave channel carries one command per item: tuser holds the command,
//   tdata the slots, values, fault address and allowed mask. Range and order
//   writes load the profile table; a fault query picks the huge page orders.
//   The master channel returns exactly one result item per input item, with
//   the status in tuser and the order mask, top order, valid flag and range
//   index in tdata.
//   Writes, bad order masks and disabled queries go straight to the result; a
//   query scans the ranges until one matches, then the allowed order slots
//   from the top down, with one memory read per cycle each. One item at a time.
//   Reset clears the enable register and marks every table entry as invalid at
//   once; items are taken in the first cycle after reset.
//   A result waits in the output register while the receiver stalls; the next
//   item is accepted meanwhile and holds in its last step until the register
//   frees.
module huge_page_order_selector #(
  parameter int NUM_RANGES = 10,
  parameter int NUM_ORDERS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic         cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // range_slot[3:0], order_slot[6:4], first_value[70:7], second_value[134:71],
  // query_addr[198:135], allowed_orders[214:199], zero[215]
  input  logic [215:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // chosen_orders[8:0], top_order[12:9], order_valid[13], matched_range[17:14],
  // zero[23:18]
  output logic [23:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser
);

  hpos_pkg::ctrl_cmd_t  cmd;
  hpos_pkg::dp_status_t dp_st;
  logic [8:0] chosen;
  logic [3:0] top;
  logic       ovalid;
  logic [3:0] mrange;

  hpos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dp_st     (dp_st),
    .cmd       (cmd)
  );

  hpos_dp #(
    .NUM_RANGES (NUM_RANGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .dp_st             (dp_st),
    .in_command        (s_axis_tuser),
    .in_range_slot     (s_axis_tdata[3:0]),
    .in_order_slot     (s_axis_tdata[6:4]),
    .in_first_value    (s_axis_tdata[70:7]),
    .in_second_value   (s_axis_tdata[134:71]),
    .in_query_addr     (s_axis_tdata[198:135]),
    .in_allowed_orders (s_axis_tdata[214:199]),
    .res_status        (m_axis_tuser),
    .res_chosen_orders (chosen),
    .res_top_order     (top),
    .res_order_valid   (ovalid),
    .res_matched_range (mrange)
  );

  assign m_axis_tdata = {6'd0, mrange, ovalid, top, chosen};

endmodule
